FILE: design/lsse_pkg.sv
package lsse_pkg;

    // sizing
    localparam int TABLE_DEPTH = 4096;
    localparam int MAX_ORDER   = 8;
    localparam int MAX_DIM     = 32;

    localparam int ADDR_W   = $clog2(TABLE_DEPTH);
    localparam int N_W      = $clog2(TABLE_DEPTH + 1);
    localparam int ORD_W    = $clog2(MAX_ORDER + 2);
    localparam int ORDER_IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CNT_W    = 6;

    // index reduction: 12x12 product, a few remainder bits per cycle
    localparam int PROD_W   = 24;
    localparam int DIV_BITS = 4;
    localparam int DIV_CYC  = PROD_W / DIV_BITS;
    localparam int DCNT_W   = $clog2(DIV_CYC);

    // queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_LIMIT = 1'd1;
    localparam logic [12:0] MODULUS_RESET     = 13'd4096;
    localparam logic [3:0]  ORDER_LIMIT_RESET = 4'd8;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_COORD = 1'b1;

    // q24.40 constants
    localparam logic [63:0] ONE_Q40   = 64'h0000_0100_0000_0000;
    localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic               kind;
        logic [11:0]        table_index;
        logic signed [31:0] table_value;
        logic [11:0]        point_number;
        logic [11:0]        multiplier;
        logic               last_coord;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         coord_count;
        logic [5:0]         sum_order;
        logic signed [63:0] sum_value;
        logic               run_end;
    } t_out_item;

    // one classified coordinate handed from front to back
    typedef struct packed {
        logic signed [31:0] weight;
        logic               last;
    } t_work;

endpackage

FILE: design/lattice_symmetric_sum_engine_top.sv
// front end: a coordinate item takes 6 remainder steps, a table read and a queue write
//   before the next item is taken, while load items are taken back to back; back end:
//   one issue slot per order plus the product, then the 4-stage term pipeline drains
// reset: sums to zero, product to one, count to zero, modulus 4096, order limit 8;
//   the weight table is not cleared and holds garbage until loaded
module lattice_symmetric_sum_engine_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item input
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lsse_pkg::t_in_item              i_in_item,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lsse_pkg::t_out_item             o_out_item,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [lsse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsse_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lsse_pkg::*;

    logic [12:0] r_modulus;
    logic [3:0]  r_order_limit;

    // front to queue
    logic  push_valid;
    logic  push_ready;
    t_work push_item;

    // queue to back
    logic  work_valid;
    logic  work_pop;
    t_work work_item;

    // config registers, written by the user only while the block is idle (not enforced)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus     <= MODULUS_RESET;
            r_order_limit <= ORDER_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODULUS:     r_modulus     <= i_cfg_data[12:0];
                CFG_ORDER_LIMIT: r_order_limit <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // front: takes items, writes weights, reduces k*z mod n and reads the weight
    lsse_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_modulus    (r_modulus),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    // short queue so front and back stall independently
    lsse_fifo u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (push_valid),
        .o_wr_ready (push_ready),
        .i_wr_item  (push_item),
        .o_rd_valid (work_valid),
        .i_rd_pop   (work_pop),
        .o_rd_item  (work_item)
    );

    // back: symmetric-sum update, one term per cycle while issuing unless the output stalls,
    // results through an output register; a stalled result holds the term pipeline
    lsse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_order_limit (r_order_limit),
        .i_work_valid  (work_valid),
        .i_work        (work_item),
        .o_work_pop    (work_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_item    (o_out_item)
    );

endmodule

FILE: design/lsse_ram.sv
module lsse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/lsse_front.sv
module lsse_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [12:0]        i_modulus,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lsse_pkg::t_in_item i_in_item,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output lsse_pkg::t_work    o_push_item
);
    import lsse_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_READ = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]        r_fstate;
    logic [PROD_W-1:0] r_prod;
    logic [N_W-1:0]    r_n;
    logic [N_W-1:0]    r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_last;

    logic              accept;
    logic              ram_we;
    logic [31:0]       ram_rdata;
    logic [N_W-1:0]    n_sat;
    logic [N_W:0]      trial;
    logic [N_W-1:0]    rem_step;
    logic [PROD_W-1:0] div_shift;

    assign o_in_ready = (r_fstate == F_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign ram_we     = accept && (i_in_item.kind == KIND_LOAD)
                        && (int'(i_in_item.table_index) < TABLE_DEPTH);

    // clamp n into 1..table depth
    always_comb begin
        if (i_modulus == '0) begin
            n_sat = N_W'(1);
        end else if (int'(i_modulus) > TABLE_DEPTH) begin
            n_sat = N_W'(TABLE_DEPTH);
        end else begin
            n_sat = N_W'(i_modulus);
        end
    end

    // restoring remainder, a few product bits per cycle
    always_comb begin
        rem_step  = r_rem;
        div_shift = r_prod;
        trial     = '0;
        for (int b = 0; b < DIV_BITS; b++) begin
            trial     = {rem_step, div_shift[PROD_W-1]};
            div_shift = div_shift << 1;
            if (trial >= {1'b0, r_n}) begin
                trial = trial - {1'b0, r_n};
            end
            rem_step = trial[N_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstate <= F_IDLE;
        end else begin
            case (r_fstate)
                F_IDLE: begin
                    if (accept && (i_in_item.kind == KIND_COORD)) begin
                        r_fstate <= F_DIV;
                    end
                end
                F_DIV: begin
                    if (r_dcnt == DCNT_W'(DIV_CYC - 1)) begin
                        r_fstate <= F_READ;
                    end
                end
                F_READ: begin
                    r_fstate <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_push_ready) begin
                        r_fstate <= F_IDLE;
                    end
                end
                default: begin
                    r_fstate <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod <= PROD_W'(i_in_item.point_number) * PROD_W'(i_in_item.multiplier);
            r_n    <= n_sat;
            r_rem  <= '0;
            r_dcnt <= '0;
            r_last <= i_in_item.last_coord;
        end else if (r_fstate == F_DIV) begin
            r_rem  <= rem_step;
            r_prod <= div_shift;
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    lsse_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(i_in_item.table_index)),
        .i_wdata (i_in_item.table_value),
        .i_re    (r_fstate == F_READ),
        .i_raddr (ADDR_W'(r_rem)),
        .o_rdata (ram_rdata)
    );

    assign o_push_valid       = (r_fstate == F_PUSH);
    assign o_push_item.weight = ram_rdata;
    assign o_push_item.last   = r_last;

    a_rem_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fstate == F_READ) |-> (r_rem < r_n))
        else $error("table index not reduced below modulus");

endmodule

FILE: design/lsse_fifo.sv
module lsse_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    input  lsse_pkg::t_work i_wr_item,
    output logic            o_rd_valid,
    input  logic            i_rd_pop,
    output lsse_pkg::t_work o_rd_item
);
    import lsse_pkg::*;

    t_work              r_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0] r_wr_ptr;
    logic [FIFO_PW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_wr_ready = (r_count != FIFO_CW'(FIFO_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign do_wr      = i_wr_valid && o_wr_ready;
    assign do_rd      = i_rd_pop && o_rd_valid;
    assign o_rd_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_pop |-> (r_count != '0))
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: design/lsse_back.sv
module lsse_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [3:0]          i_order_limit,
    input  logic                i_work_valid,
    input  lsse_pkg::t_work     i_work,
    output logic                o_work_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lsse_pkg::t_out_item o_out_item
);
    import lsse_pkg::*;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_ISSUE = 2'd1;
    localparam logic [1:0] B_DRAIN = 2'd2;

    // running point state
    logic [1:0]          r_bstate;
    logic [63:0]         r_sums [MAX_ORDER];
    logic [63:0]         r_product;
    logic [CNT_W-1:0]    r_count;

    // current coordinate
    logic [31:0]         r_x;
    logic                r_last;
    logic [ORD_W-1:0]    r_lim;
    logic [ORD_W-1:0]    r_ord;
    logic [63:0]         r_prev;

    // term pipeline
    logic                r1_valid, r2_valid, r3_valid, r4_valid;
    logic [63:0]         r1_mag_e;
    logic [31:0]         r1_mag_x;
    logic                r1_neg, r2_neg, r3_neg;
    logic [63:0]         r1_cur, r2_cur, r3_cur, r4_cur;
    logic [ORD_W-1:0]    r1_ord, r2_ord, r3_ord, r4_ord;
    logic                r1_prod, r2_prod, r3_prod, r4_prod;
    logic [ORDER_IW-1:0] r1_idx, r2_idx, r3_idx, r4_idx;
    logic [63:0]         r2_lo, r2_hi;
    logic [63:0]         r3_q;
    logic                r3_ovf;
    logic [63:0]         r4_term;

    logic                r_out_valid;
    t_out_item           r_out;

    logic                adv;
    logic                issuing;
    logic                issue_prod;
    logic                pipe_busy;
    logic [ORD_W-1:0]    lim;
    logic [CNT_W-1:0]    cnt_inc;
    logic [ORDER_IW-1:0] sidx;
    logic [63:0]         cur;
    logic [63:0]         op_e;
    logic [63:0]         mag_e;
    logic [31:0]         mag_x;
    logic [63:0]         term;
    logic [63:0]         sum;
    logic [63:0]         sat_sum;
    logic [63:0]         result;
    t_out_item           n_out;

    assign adv        = !r_out_valid || i_out_ready;
    assign o_work_pop = (r_bstate == B_IDLE) && i_work_valid;
    assign issuing    = (r_bstate == B_ISSUE) && adv;
    assign issue_prod = (r_ord > r_lim);
    assign pipe_busy  = r1_valid || r2_valid || r3_valid || r4_valid;
    assign cnt_inc    = (int'(r_count) < MAX_DIM) ? r_count + 1'b1 : r_count;

    always_comb begin
        if (i_order_limit == 4'd0) begin
            lim = ORD_W'(1);
        end else if (int'(i_order_limit) > MAX_ORDER) begin
            lim = ORD_W'(MAX_ORDER);
        end else begin
            lim = ORD_W'(i_order_limit);
        end
    end

    // issue: order j uses old e_(j-1) from r_prev, product uses the product
    assign sidx  = ORDER_IW'(r_ord - 1'b1);
    assign cur   = issue_prod ? '0 : r_sums[sidx];
    assign op_e  = issue_prod ? r_product : r_prev;
    assign mag_e = op_e[63] ? (64'd0 - op_e) : op_e;
    assign mag_x = r_x[31] ? (32'd0 - r_x) : r_x;

    // sign and saturate the rounded magnitude
    always_comb begin
        if (r3_ovf) begin
            term = r3_neg ? NEG_LIMIT : POS_LIMIT;
        end else if (r3_neg) begin
            term = (r3_q > NEG_LIMIT) ? NEG_LIMIT : (64'd0 - r3_q);
        end else begin
            term = (r3_q > POS_LIMIT) ? POS_LIMIT : r3_q;
        end
    end

    // saturating accumulate
    assign sum = r4_cur + r4_term;
    always_comb begin
        if ((r4_cur[63] == r4_term[63]) && (sum[63] != r4_cur[63])) begin
            sat_sum = r4_cur[63] ? NEG_LIMIT : POS_LIMIT;
        end else begin
            sat_sum = sum;
        end
    end
    assign result = r4_prod ? r4_term : sat_sum;

    always_comb begin
        n_out.coord_count = r_count;
        n_out.sum_order   = r4_prod ? r_count : CNT_W'(r4_ord);
        n_out.sum_value   = result;
        n_out.run_end     = r4_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate    <= B_IDLE;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_product   <= ONE_Q40;
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_sums[i] <= '0;
            end
        end else begin
            if (adv) begin
                r1_valid    <= issuing;
                r2_valid    <= r1_valid;
                r3_valid    <= r2_valid;
                r4_valid    <= r3_valid;
                r_out_valid <= r4_valid;
                if (r4_valid) begin
                    if (r4_prod) begin
                        r_product <= result;
                    end else begin
                        r_sums[r4_idx] <= result;
                    end
                end
            end
            case (r_bstate)
                B_IDLE: begin
                    if (i_work_valid) begin
                        r_bstate <= B_ISSUE;
                        r_count  <= cnt_inc;
                    end
                end
                B_ISSUE: begin
                    if (adv && issue_prod) begin
                        r_bstate <= B_DRAIN;
                    end
                end
                B_DRAIN: begin
                    if (!pipe_busy) begin
                        if (r_last) begin
                            r_count   <= '0;
                            r_product <= ONE_Q40;
                            for (int i = 0; i < MAX_ORDER; i++) begin
                                r_sums[i] <= '0;
                            end
                        end
                        r_bstate <= B_IDLE;
                    end
                end
                default: begin
                    r_bstate <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_work_pop) begin
            r_x    <= i_work.weight;
            r_last <= i_work.last;
            r_lim  <= lim;
            r_ord  <= ORD_W'(1);
            r_prev <= ONE_Q40;
        end else if (issuing) begin
            r_ord  <= r_ord + 1'b1;
            r_prev <= cur;
        end
        if (adv) begin
            r1_mag_e <= mag_e;
            r1_mag_x <= mag_x;
            r1_neg   <= op_e[63] ^ r_x[31];
            r1_cur   <= cur;
            r1_ord   <= r_ord;
            r1_prod  <= issue_prod;
            r1_idx   <= sidx;

            r2_lo    <= 64'(r1_mag_e[31:0]) * 64'(r1_mag_x);
            r2_hi    <= 64'(r1_mag_e[63:32]) * 64'(r1_mag_x);
            r2_neg   <= r1_neg;
            r2_cur   <= r1_cur;
            r2_ord   <= r1_ord;
            r2_prod  <= r1_prod;
            r2_idx   <= r1_idx;

            // round half away from zero: carry in bit 23 of the low part
            r3_q     <= (r2_hi << 8) + {24'd0, r2_lo[63:24]} + {63'd0, r2_lo[23]};
            r3_ovf   <= |r2_hi[63:55];
            r3_neg   <= r2_neg;
            r3_cur   <= r2_cur;
            r3_ord   <= r2_ord;
            r3_prod  <= r2_prod;
            r3_idx   <= r2_idx;

            r4_term  <= term;
            r4_cur   <= r3_cur;
            r4_ord   <= r3_ord;
            r4_prod  <= r3_prod;
            r4_idx   <= r3_idx;

            r_out    <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_pipe_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pipe_busy |-> (r_bstate != B_IDLE))
        else $error("term pipeline busy while back end idle");

    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.run_end) |->
            ((o_out_item.sum_order != '0) && (o_out_item.sum_order <= CNT_W'(r_lim))))
        else $error("reported order outside kept range");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_DIM))
        else $error("coordinate count beyond limit");

endmodule

FILE: bench/lattice_symmetric_sum_engine_top_test.sv
`timescale 1ns / 1ps

module lattice_symmetric_sum_engine_top_test;
    import lsse_pkg::*;

    // run bounds
    localparam int LIMIT_CYCLES  = 200_000;
    localparam int SETTLE_CYCLES = 40;  // covers the block's latency plus back end drain

    // clock, reset and block inputs, all known from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // stimulus side: items waiting for the driver and what the generator knows
    t_in_item    pending_items[$];
    bit          loaded[TABLE_DEPTH];  // table entries written so far
    logic [12:0] gen_modulus   = MODULUS_RESET;
    int unsigned items_queued  = 0;
    bit          steady        = 1'b0;  // no idling on either side while set

    // prediction side: private copy of the block's state and registers
    logic [31:0] weight_copy[TABLE_DEPTH];
    logic [63:0] sums_model[MAX_ORDER];
    logic [63:0] product_model;
    logic [5:0]  count_model;
    logic [12:0] modulus_model;
    logic [3:0]  order_model;
    t_out_item   expected_sums[$];

    int unsigned cycle_count = 0;
    int unsigned fail_count  = 0;

    lattice_symmetric_sum_engine_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // arithmetic of the sums
    // ------------------------------------------------------------------

    // n as the block uses it: zero acts as one, anything past the table as the table size
    function automatic int unsigned effective_modulus(input logic [12:0] m);
        if (m < 1)
            return 1;
        if (m > TABLE_DEPTH)
            return TABLE_DEPTH;
        return m;
    endfunction

    // q24.40 times q8.24, rounded half away from zero, saturated to 64 bits
    function automatic logic [63:0] scaled_product(input logic [63:0] e, input logic [31:0] x);
        logic [63:0]  mag_e;
        logic [31:0]  mag_x;
        logic [127:0] wide;
        logic [127:0] q;
        logic         neg;
        neg   = e[63] ^ x[31];
        mag_e = e[63] ? 64'd0 - e : e;
        mag_x = x[31] ? 32'd0 - x : x;
        wide  = {64'd0, mag_e} * {96'd0, mag_x};
        q     = (wide + 128'd8388608) >> 24;
        if (q == 0)
            return 64'd0;
        if (neg)
            return (q > {64'd0, NEG_LIMIT}) ? NEG_LIMIT : 64'd0 - q[63:0];
        return (q > {64'd0, POS_LIMIT}) ? POS_LIMIT : q[63:0];
    endfunction

    // signed 64-bit add that sticks at the limits
    function automatic logic [63:0] clamped_sum(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            return a[63] ? NEG_LIMIT : POS_LIMIT;
        return r;
    endfunction

    task automatic clear_point_model();
        for (int i = 0; i < MAX_ORDER; i++)
            sums_model[i] = 64'd0;
        product_model = ONE_Q40;
        count_model   = 6'd0;
    endtask

    // updates the model for one accepted item and queues the results it causes
    task automatic predict_symmetric_sums(input t_in_item item);
        int unsigned k;
        int unsigned z;
        int unsigned idx;
        int          lim;
        int          j;
        logic [31:0] w;
        logic [63:0] lower;
        t_out_item   r;
        if (item.kind == KIND_LOAD) begin
            weight_copy[item.table_index] = item.table_value;
            return;
        end
        k   = item.point_number;
        z   = item.multiplier;
        idx = (k * z) % effective_modulus(modulus_model);
        w   = weight_copy[idx];
        lim = order_model;
        if (lim < 1)
            lim = 1;
        if (lim > MAX_ORDER)
            lim = MAX_ORDER;
        // highest order first so each update sees the previous coordinate's sums
        for (j = lim; j >= 1; j--) begin
            lower = (j == 1) ? ONE_Q40 : sums_model[j-2];
            sums_model[j-1] = clamped_sum(sums_model[j-1], scaled_product(lower, w));
        end
        product_model = scaled_product(product_model, w);
        if (count_model < MAX_DIM)
            count_model = count_model + 6'd1;
        for (j = 1; j <= lim; j++) begin
            r.coord_count = count_model;
            r.sum_order   = j[5:0];
            r.sum_value   = sums_model[j-1];
            r.run_end     = 1'b0;
            expected_sums.push_back(r);
        end
        r.coord_count = count_model;
        r.sum_order   = count_model;
        r.sum_value   = product_model;
        r.run_end     = 1'b1;
        expected_sums.push_back(r);
        if (item.last_coord)
            clear_point_model();
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_sums.size() == 0) begin
            $display("%0t: result with nothing expected: got %h", $time, got);
            fail_count++;
        end else begin
            want = expected_sums.pop_front();
            if (got.coord_count !== want.coord_count) begin
                $display("%0t: coord_count expected %0d got %0d",
                         $time, want.coord_count, got.coord_count);
                fail_count++;
            end
            if (got.sum_order !== want.sum_order) begin
                $display("%0t: sum_order expected %0d got %0d",
                         $time, want.sum_order, got.sum_order);
                fail_count++;
            end
            if (got.sum_value !== want.sum_value) begin
                $display("%0t: sum_value expected %h got %h",
                         $time, want.sum_value, got.sum_value);
                fail_count++;
            end
            if (got.run_end !== want.run_end) begin
                $display("%0t: run_end expected %b got %b", $time, want.run_end, got.run_end);
                fail_count++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver: next item from the queue once the current one is taken
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!in_valid || in_ready) begin
            if (rst_n && pending_items.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= 16);
    end

    // ------------------------------------------------------------------
    // monitor: register writes, accepted items and results, plus the timeout
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("lattice_symmetric_sum_engine_top test failed");
            $finish;
        end else if (!rst_n) begin
            clear_point_model();
            modulus_model = MODULUS_RESET;
            order_model   = ORDER_LIMIT_RESET;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MODULUS:     modulus_model = cfg_data[12:0];
                    CFG_ORDER_LIMIT: order_model   = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_symmetric_sums(in_item);
            if (out_valid && out_ready)
                check_result(out_item);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // mostly weights near one so sums stay in range, sometimes extremes, tiny values or any pattern
    function automatic logic [31:0] random_weight();
        logic [31:0] v;
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return $urandom_range(0, 255) - 32'd128;
            default: begin
                v = 32'h00C0_0000 + $urandom_range(0, 32'h0080_0000);
                return $urandom_range(1) ? v : 32'd0 - v;
            end
        endcase
    endfunction

    task automatic queue_item(input t_in_item item);
        pending_items.push_back(item);
        items_queued++;
    endtask

    // fields a load does not use are random, last_coord included
    task automatic queue_load(input int unsigned idx, input logic [31:0] value);
        t_in_item item;
        item.kind         = KIND_LOAD;
        item.table_index  = 12'(idx);
        item.table_value  = value;
        item.point_number = 12'($urandom());
        item.multiplier   = 12'($urandom());
        item.last_coord   = 1'($urandom());
        queue_item(item);
        loaded[idx] = 1'b1;
    endtask

    // a coordinate that would hit an unwritten entry gets a load in front of it
    task automatic queue_coord(input int unsigned k, input int unsigned z, input logic last);
        t_in_item    item;
        int unsigned idx;
        idx = (k * z) % effective_modulus(gen_modulus);
        if (!loaded[idx])
            queue_load(idx, random_weight());
        item.kind         = KIND_COORD;
        item.table_index  = 12'($urandom());
        item.table_value  = $urandom();
        item.point_number = 12'(k);
        item.multiplier   = 12'(z);
        item.last_coord   = last;
        queue_item(item);
    endtask

    // points of random length with random content, some left open, loads in between
    task automatic queue_random_points(input int unsigned budget);
        int unsigned start;
        int unsigned len;
        int unsigned span;
        logic        last;
        start = items_queued;
        while (items_queued - start < budget) begin
            span = effective_modulus(gen_modulus);
            if ($urandom_range(4) == 0) begin
                queue_load($urandom_range(3) == 0 ? $urandom_range(4095)
                                                  : $urandom_range(span - 1),
                           random_weight());
            end else begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    last = (i == len - 1) && ($urandom_range(9) != 0);
                    queue_coord($urandom_range(4095), $urandom_range(4095), last);
                end
            end
        end
    endtask

    // idle means every item taken and every result seen, then the pipe gets time to empty;
    // checked at the falling edge so the driver's updates have settled
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_sums.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MODULUS)
            gen_modulus = data;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] modulus,
                             input logic [CFG_DATA_W-1:0] order_data,
                             input int unsigned budget);
        wait_drained();
        write_register(CFG_MODULUS, modulus);
        write_register(CFG_ORDER_LIMIT, order_data);
        queue_random_points(budget);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: table extremes and the weights the special cases need
        queue_load(0, 32'h7FFF_FFFF);
        queue_load(4095, 32'h8000_0000);
        queue_load(1, 32'h0000_0001);
        queue_load(2, 32'h0000_0080);
        queue_load(3, 32'hFFFF_FF80);
        queue_load(4, 32'h0100_0000);

        // largest weight four times drives the fourth-order sum and the product into positive saturation,
        // then the most negative weight flips the product to negative saturation
        queue_coord(0, 4095, 1'b0);
        queue_coord(4095, 0, 1'b0);
        queue_coord(0, 0, 1'b0);
        queue_coord(2048, 2048, 1'b0);
        queue_coord(4095, 1, 1'b1);

        // tiny weight, then terms of exactly one half, rounded away from zero both ways
        queue_coord(4095, 4095, 1'b0);
        queue_coord(2, 1, 1'b0);
        queue_coord(1, 3, 1'b1);

        // lowering the order limit mid-point holds the upper orders, raising it resumes them
        queue_coord(4, 1, 1'b0);
        queue_coord(1, 4, 1'b0);
        wait_drained();
        write_register(CFG_ORDER_LIMIT, 13'd0);
        queue_coord(2, 2, 1'b0);
        wait_drained();
        write_register(CFG_ORDER_LIMIT, 13'd8);
        queue_coord(4, 1, 1'b1);

        // random phases over the register range, out-of-range values included
        run_phase(13'd0, 13'd8, 20);
        run_phase(13'd1, 13'd1, 20);
        steady = 1'b1;
        run_phase(13'd8191, 13'd15, 20);
        wait_drained();
        steady = 1'b0;
        run_phase(13'd4097, 13'd9, 20);
        run_phase(13'd7, 13'd3, 20);
        run_phase(13'd100, 13'd0, 20);
        run_phase(13'h0BB8, 13'h1FF5, 20);
        run_phase(13'd4096, 13'd8, 20);

        // one point longer than the coordinate count can show
        wait_drained();
        write_register(CFG_MODULUS, 13'd16);
        for (int i = 0; i < 16; i++)
            queue_load(i, 32'h00F0_0000 + $urandom_range(0, 32'h0020_0000));
        for (int i = 0; i < MAX_DIM + 2; i++)
            queue_coord($urandom_range(4095), $urandom_range(4095), i == MAX_DIM + 1);

        wait_drained();
        if (fail_count == 0)
            $display("lattice_symmetric_sum_engine_top test passed");
        else
            $display("lattice_symmetric_sum_engine_top test failed");
        $finish;
    end

endmodule

FILE: lattice_symmetric_sum_engine_top.f
design/lsse_pkg.sv
design/lsse_ram.sv
design/lsse_front.sv
design/lsse_fifo.sv
design/lsse_back.sv
design/lattice_symmetric_sum_engine_top.sv
bench/lattice_symmetric_sum_engine_top_test.sv
